@@ src/yuyv_pkg.sv @@
// Shared types, widths and fixed-point constants for the YUYV to RGB pipeline.
// No dependencies; imported by every module of the block.
package yuyv_pkg;

   localparam int PIX_W     = 8;
   localparam int COEF_W    = 17;
   localparam int PROD_W    = 25;
   localparam int SUM_W     = 27;
   localparam int FRAC_BITS = 16;

   // Q1.16 coefficients, rounded to nearest
   localparam logic [COEF_W-1:0] COEF_R_V = 17'd89831;
   localparam logic [COEF_W-1:0] COEF_G_V = 17'd45744;
   localparam logic [COEF_W-1:0] COEF_G_U = 17'd22127;
   localparam logic [COEF_W-1:0] COEF_B_U = 17'd113538;

   localparam logic [PIX_W:0]   CHROMA_OFFSET = 9'd128;
   localparam logic [PIX_W-1:0] CLAMP_MAX     = 8'd255;
   localparam logic [PIX_W-1:0] SCALE_NUM     = 8'd220;

   typedef struct packed {
      logic valid;
      logic frame_end;
   } ctl_type;

   typedef struct packed {
      logic [PIX_W-1:0]         luma_first;
      logic [PIX_W-1:0]         luma_second;
      logic signed [PROD_W-1:0] r_v;
      logic signed [PROD_W-1:0] g_v;
      logic signed [PROD_W-1:0] g_u;
      logic signed [PROD_W-1:0] b_u;
   } prod_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } pixel_type;

endpackage

@@ src/yuyv_to_rgb_converter.sv @@
// Top level of the YUYV 4:2:2 to scaled RGB888 converter.
// Depends on yuyv_pkg, yuyv_mult, yuyv_sum_clamp and yuyv_scale.
//
//   channel   handshake                 payload
//   request   start / busy (accept on   req_luma_first, req_chroma_blue,
//             start && !busy)           req_luma_second, req_chroma_red, req_frame_end
//   response  rsp_valid, one cycle      rsp_{red,green,blue}_{first,second},
//                                       rsp_frame_end_out
//
// Four register stages: input capture, chroma products, sum and clamp, scale.
// A request accepted at an edge moves through these registers in order and shows
// on the response ports for a single cycle; one request per clock, sustained.
// busy is held low: nothing in the pipe ever waits, and the receiver cannot stall.
// Synchronous reset clears the valid bits of all stages; data registers are not reset.
module yuyv_to_rgb_converter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [yuyv_pkg::PIX_W-1:0]  req_luma_first,
   input  logic [yuyv_pkg::PIX_W-1:0]  req_chroma_blue,
   input  logic [yuyv_pkg::PIX_W-1:0]  req_luma_second,
   input  logic [yuyv_pkg::PIX_W-1:0]  req_chroma_red,
   input  logic                        req_frame_end,
   output logic                        rsp_valid,
   output logic [yuyv_pkg::PIX_W-1:0]  rsp_red_first,
   output logic [yuyv_pkg::PIX_W-1:0]  rsp_green_first,
   output logic [yuyv_pkg::PIX_W-1:0]  rsp_blue_first,
   output logic [yuyv_pkg::PIX_W-1:0]  rsp_red_second,
   output logic [yuyv_pkg::PIX_W-1:0]  rsp_green_second,
   output logic [yuyv_pkg::PIX_W-1:0]  rsp_blue_second,
   output logic                        rsp_frame_end_out
);
   import yuyv_pkg::*;

   // stage 0: capture request, remove chroma offset
   ctl_type                  ctl_s0_ff, ctl_s0_in;
   logic [PIX_W-1:0]         luma_first_ff, luma_second_ff;
   logic signed [PIX_W-1:0]  du_ff, du_in;
   logic signed [PIX_W-1:0]  dv_ff, dv_in;
   logic [PIX_W:0]           du_wide, dv_wide;

   ctl_type   ctl_s1, ctl_s2, ctl_s3;
   prod_type  prod_s1;
   pixel_type pix_first_s2, pix_second_s2;
   pixel_type pix_first_s3, pix_second_s3;

   assign busy = 1'b0;

   always_comb begin
      ctl_s0_in.valid     = start && !busy;
      ctl_s0_in.frame_end = req_frame_end;
      // chroma minus 128 always fits in eight signed bits
      du_wide = {1'b0, req_chroma_blue} - CHROMA_OFFSET;
      dv_wide = {1'b0, req_chroma_red} - CHROMA_OFFSET;
      du_in   = du_wide[PIX_W-1:0];
      dv_in   = dv_wide[PIX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_s0_ff <= '0;
      end else begin
         ctl_s0_ff <= ctl_s0_in;
      end
      luma_first_ff  <= req_luma_first;
      luma_second_ff <= req_luma_second;
      du_ff          <= du_in;
      dv_ff          <= dv_in;
   end

   // stage 1: coefficient products
   yuyv_mult u_mult (
      .clock       (clock),
      .reset       (reset),
      .ctl_i       (ctl_s0_ff),
      .luma_first  (luma_first_ff),
      .luma_second (luma_second_ff),
      .du          (du_ff),
      .dv          (dv_ff),
      .ctl_o       (ctl_s1),
      .prod_o      (prod_s1)
   );

   // stage 2: Q.16 sums, truncation and clamp
   yuyv_sum_clamp u_sum (
      .clock        (clock),
      .reset        (reset),
      .ctl_i        (ctl_s1),
      .prod_i       (prod_s1),
      .ctl_o        (ctl_s2),
      .pix_first_o  (pix_first_s2),
      .pix_second_o (pix_second_s2)
   );

   // stage 3: 220/256 scaling, doubles as the output register
   yuyv_scale u_scale (
      .clock        (clock),
      .reset        (reset),
      .ctl_i        (ctl_s2),
      .pix_first_i  (pix_first_s2),
      .pix_second_i (pix_second_s2),
      .ctl_o        (ctl_s3),
      .pix_first_o  (pix_first_s3),
      .pix_second_o (pix_second_s3)
   );

   assign rsp_valid         = ctl_s3.valid;
   assign rsp_frame_end_out = ctl_s3.frame_end;
   assign rsp_red_first     = pix_first_s3.red;
   assign rsp_green_first   = pix_first_s3.green;
   assign rsp_blue_first    = pix_first_s3.blue;
   assign rsp_red_second    = pix_second_s3.red;
   assign rsp_green_second  = pix_second_s3.green;
   assign rsp_blue_second   = pix_second_s3.blue;

endmodule

@@ src/yuyv_mult.sv @@
// Chroma product stage: four coefficient-by-chroma products, registered.
// Depends on yuyv_pkg.
module yuyv_mult (
   input  logic                                clock,
   input  logic                                reset,
   input  yuyv_pkg::ctl_type                   ctl_i,
   input  logic [yuyv_pkg::PIX_W-1:0]          luma_first,
   input  logic [yuyv_pkg::PIX_W-1:0]          luma_second,
   input  logic signed [yuyv_pkg::PIX_W-1:0]   du,
   input  logic signed [yuyv_pkg::PIX_W-1:0]   dv,
   output yuyv_pkg::ctl_type                   ctl_o,
   output yuyv_pkg::prod_type                  prod_o
);
   import yuyv_pkg::*;

   ctl_type  ctl_ff;
   prod_type prod_ff, prod_in;

   function automatic logic signed [PROD_W-1:0] mul(input logic [COEF_W-1:0] c,
                                                    input logic signed [PIX_W-1:0] d);
      logic signed [COEF_W+PIX_W:0] full;
      full = $signed({1'b0, c}) * d;
      return full[PROD_W-1:0];
   endfunction

   always_comb begin
      prod_in.luma_first  = luma_first;
      prod_in.luma_second = luma_second;
      prod_in.r_v         = mul(COEF_R_V, dv);
      prod_in.g_v         = mul(COEF_G_V, dv);
      prod_in.g_u         = mul(COEF_G_U, du);
      prod_in.b_u         = mul(COEF_B_U, du);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
      prod_ff <= prod_in;
   end

   assign ctl_o  = ctl_ff;
   assign prod_o = prod_ff;

endmodule

@@ src/yuyv_sum_clamp.sv @@
// Sum stage: luma plus chroma products in Q.16, truncated and clamped to 0..255.
// Depends on yuyv_pkg.
module yuyv_sum_clamp (
   input  logic                 clock,
   input  logic                 reset,
   input  yuyv_pkg::ctl_type    ctl_i,
   input  yuyv_pkg::prod_type   prod_i,
   output yuyv_pkg::ctl_type    ctl_o,
   output yuyv_pkg::pixel_type  pix_first_o,
   output yuyv_pkg::pixel_type  pix_second_o
);
   import yuyv_pkg::*;

   ctl_type   ctl_ff;
   pixel_type first_ff, first_in;
   pixel_type second_ff, second_in;

   // negative sums go to zero; positive ones truncate by dropping the fraction and saturate at 255
   function automatic logic [PIX_W-1:0] clamp(input logic signed [SUM_W-1:0] s);
      logic [SUM_W-FRAC_BITS-1:0] whole;
      whole = s[SUM_W-1:FRAC_BITS];
      if (s[SUM_W-1]) begin
         return '0;
      end else if (whole > (SUM_W-FRAC_BITS)'(CLAMP_MAX)) begin
         return CLAMP_MAX;
      end else begin
         return whole[PIX_W-1:0];
      end
   endfunction

   function automatic pixel_type convert(input logic [PIX_W-1:0] y, input prod_type p);
      logic signed [SUM_W-1:0] base;
      pixel_type px;
      base     = $signed({{(SUM_W-PIX_W-FRAC_BITS){1'b0}}, y, {FRAC_BITS{1'b0}}});
      px.red   = clamp(base + SUM_W'(p.r_v));
      px.green = clamp(base - SUM_W'(p.g_v) - SUM_W'(p.g_u));
      px.blue  = clamp(base + SUM_W'(p.b_u));
      return px;
   endfunction

   always_comb begin
      first_in  = convert(prod_i.luma_first, prod_i);
      second_in = convert(prod_i.luma_second, prod_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
      first_ff  <= first_in;
      second_ff <= second_in;
   end

   assign ctl_o        = ctl_ff;
   assign pix_first_o  = first_ff;
   assign pix_second_o = second_ff;

endmodule

@@ src/yuyv_scale.sv @@
// Output stage: scales each clamped channel by 220/256 with truncation.
// Depends on yuyv_pkg.
module yuyv_scale (
   input  logic                 clock,
   input  logic                 reset,
   input  yuyv_pkg::ctl_type    ctl_i,
   input  yuyv_pkg::pixel_type  pix_first_i,
   input  yuyv_pkg::pixel_type  pix_second_i,
   output yuyv_pkg::ctl_type    ctl_o,
   output yuyv_pkg::pixel_type  pix_first_o,
   output yuyv_pkg::pixel_type  pix_second_o
);
   import yuyv_pkg::*;

   ctl_type   ctl_ff;
   pixel_type first_ff, first_in;
   pixel_type second_ff, second_in;

   function automatic logic [PIX_W-1:0] scale(input logic [PIX_W-1:0] c);
      logic [2*PIX_W-1:0] p;
      p = {{PIX_W{1'b0}}, c} * {{PIX_W{1'b0}}, SCALE_NUM};
      return p[2*PIX_W-1:PIX_W];
   endfunction

   function automatic pixel_type scale_px(input pixel_type px);
      pixel_type q;
      q.red   = scale(px.red);
      q.green = scale(px.green);
      q.blue  = scale(px.blue);
      return q;
   endfunction

   always_comb begin
      first_in  = scale_px(pix_first_i);
      second_in = scale_px(pix_second_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
      first_ff  <= first_in;
      second_ff <= second_in;
   end

   assign ctl_o        = ctl_ff;
   assign pix_first_o  = first_ff;
   assign pix_second_o = second_ff;

endmodule

@@ src/yuyv_checker.sv @@
// Port-level checks for yuyv_to_rgb_converter, attached by bind.
// Depends on yuyv_pkg and on the port list of the top level.
module yuyv_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        req_frame_end,
   input logic                        rsp_valid,
   input logic [yuyv_pkg::PIX_W-1:0]  rsp_red_first,
   input logic [yuyv_pkg::PIX_W-1:0]  rsp_green_first,
   input logic [yuyv_pkg::PIX_W-1:0]  rsp_blue_first,
   input logic [yuyv_pkg::PIX_W-1:0]  rsp_red_second,
   input logic [yuyv_pkg::PIX_W-1:0]  rsp_green_second,
   input logic [yuyv_pkg::PIX_W-1:0]  rsp_blue_second,
   input logic                        rsp_frame_end_out
);
   import yuyv_pkg::*;

   localparam logic [PIX_W-1:0] OUT_MAX = 8'd219;

   // every accepted request is answered with rsp_valid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("request not answered after four cycles");

   // no response without a matching earlier request
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("response without matching request");

   // frame flag travels with its macropixel
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_end_out == $past(req_frame_end, 4)))
      else $error("frame end flag out of step");

   // scaled channels never exceed 219
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_red_first <= OUT_MAX && rsp_green_first <= OUT_MAX &&
                     rsp_blue_first <= OUT_MAX && rsp_red_second <= OUT_MAX &&
                     rsp_green_second <= OUT_MAX && rsp_blue_second <= OUT_MAX))
      else $error("scaled channel above 219");

   // pipeline never pushes back
   a_never_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");

endmodule

bind yuyv_to_rgb_converter yuyv_checker u_yuyv_checker (.*);

@@ test/testbench.sv @@
// Self-checking testbench for yuyv_to_rgb_converter: directed and random macropixel
// requests against a bit-exact fixed-point predictor of the color conversion.
// Depends on yuyv_pkg and the converter RTL.
module testbench;
   import yuyv_pkg::*;

   // Q1.16 conversion coefficients (value * 65536, rounded to nearest)
   localparam longint K_RED_V   = 89831;
   localparam longint K_GREEN_V = 45744;
   localparam longint K_GREEN_U = 22127;
   localparam longint K_BLUE_U  = 113538;
   localparam longint UV_BIAS   = 128;
   localparam longint Q16_ONE   = 65536;
   localparam longint OUT_SCALE = 220;
   localparam longint BYTE_MAX  = 255;

   localparam int RANDOM_REQUESTS = 400;
   localparam int BURST_LEN       = 40;   // random requests alternate burst / gappy blocks
   localparam int MAX_GAP         = 5;
   localparam int TAIL_CYCLES     = 10;   // pipe is four stages deep
   localparam int RUN_LIMIT       = 400000;

   typedef struct {
      logic [PIX_W-1:0] luma_first;
      logic [PIX_W-1:0] chroma_blue;
      logic [PIX_W-1:0] luma_second;
      logic [PIX_W-1:0] chroma_red;
      logic             frame_end;
      int unsigned      gap;          // idle cycles after this request is taken
      bit               drain_first;  // hold off until the pipe has emptied
   } macropixel_type;

   typedef struct {
      pixel_type first;
      pixel_type second;
      logic      frame_end;
   } rgb_pair_type;

   logic             clock;
   logic             reset;
   logic             start             = 1'b0;
   logic             busy;
   logic [PIX_W-1:0] req_luma_first    = '0;
   logic [PIX_W-1:0] req_chroma_blue   = '0;
   logic [PIX_W-1:0] req_luma_second   = '0;
   logic [PIX_W-1:0] req_chroma_red    = '0;
   logic             req_frame_end     = 1'b0;
   logic             rsp_valid;
   logic [PIX_W-1:0] rsp_red_first;
   logic [PIX_W-1:0] rsp_green_first;
   logic [PIX_W-1:0] rsp_blue_first;
   logic [PIX_W-1:0] rsp_red_second;
   logic [PIX_W-1:0] rsp_green_second;
   logic [PIX_W-1:0] rsp_blue_second;
   logic             rsp_frame_end_out;

   macropixel_type pending_requests[$];
   rgb_pair_type   rgb_expected[$];
   macropixel_type on_port;          // request currently presented on the req_ ports
   int unsigned idle_cycles = 0;
   int          mismatch_count = 0;

   yuyv_to_rgb_converter uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_luma_first    (req_luma_first),
      .req_chroma_blue   (req_chroma_blue),
      .req_luma_second   (req_luma_second),
      .req_chroma_red    (req_chroma_red),
      .req_frame_end     (req_frame_end),
      .rsp_valid         (rsp_valid),
      .rsp_red_first     (rsp_red_first),
      .rsp_green_first   (rsp_green_first),
      .rsp_blue_first    (rsp_blue_first),
      .rsp_red_second    (rsp_red_second),
      .rsp_green_second  (rsp_green_second),
      .rsp_blue_second   (rsp_blue_second),
      .rsp_frame_end_out (rsp_frame_end_out)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Q.16 sum -> truncate toward zero, clamp to a byte, scale by 220/256.
   // SV signed division truncates toward zero, which is what we want here.
   function automatic logic [PIX_W-1:0] clamp_and_scale(longint q16_sum);
      longint whole;
      whole = q16_sum / Q16_ONE;
      if (whole < 0) whole = 0;
      if (whole > BYTE_MAX) whole = BYTE_MAX;
      return PIX_W'((whole * OUT_SCALE) >> 8);
   endfunction

   function automatic pixel_type yuv_to_pixel(logic [PIX_W-1:0] luma, longint du, longint dv);
      longint    base;
      pixel_type px;
      base     = longint'(luma) * Q16_ONE;
      px.red   = clamp_and_scale(base + K_RED_V * dv);
      px.green = clamp_and_scale(base - K_GREEN_V * dv - K_GREEN_U * du);
      px.blue  = clamp_and_scale(base + K_BLUE_U * du);
      return px;
   endfunction

   // Both pixels of a macropixel share the chroma pair.
   function automatic rgb_pair_type convert_macropixel(macropixel_type mp);
      longint       du;
      longint       dv;
      rgb_pair_type pair;
      du             = longint'(mp.chroma_blue) - UV_BIAS;
      dv             = longint'(mp.chroma_red) - UV_BIAS;
      pair.first     = yuv_to_pixel(mp.luma_first, du, dv);
      pair.second    = yuv_to_pixel(mp.luma_second, du, dv);
      pair.frame_end = mp.frame_end;
      return pair;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------

   task automatic add_request(logic [PIX_W-1:0] y0, logic [PIX_W-1:0] u,
                              logic [PIX_W-1:0] y1, logic [PIX_W-1:0] v,
                              logic fe, int unsigned gap, bit drain);
      macropixel_type mp;
      mp.luma_first  = y0;
      mp.chroma_blue = u;
      mp.luma_second = y1;
      mp.chroma_red  = v;
      mp.frame_end   = fe;
      mp.gap         = gap;
      mp.drain_first = drain;
      pending_requests.push_back(mp);
   endtask

   // Chroma pick: mostly uniform, sometimes near neutral (120 to 136),
   // sometimes pinned to the rails.
   function automatic logic [PIX_W-1:0] pick_chroma();
      int unsigned mode;
      mode = $urandom_range(0, 9);
      if (mode < 2) return PIX_W'($urandom_range(120, 136));
      if (mode == 2) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      return PIX_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [PIX_W-1:0] pick_luma();
      if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      return PIX_W'($urandom_range(0, 255));
   endfunction

   // ------------------------------------------------------------------
   // Driver: presents one request at a time from pending_requests.
   // A request is taken at an edge with start high and busy low; its
   // expected pixel pair is queued at that same edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start       <= 1'b0;
         idle_cycles <= 0;
      end else if (start && busy) begin
         // held off: keep the request steady
      end else begin
         if (start)
            rgb_expected.push_back(convert_macropixel(on_port));

         if (idle_cycles > 0) begin
            idle_cycles <= idle_cycles - 1;
            start       <= 1'b0;
         end else if (pending_requests.size() != 0 && pending_requests[0].drain_first &&
                      rgb_expected.size() != 0) begin
            // wait for the pipe to empty before this request
            start <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            on_port          = pending_requests.pop_front();
            req_luma_first  <= on_port.luma_first;
            req_chroma_blue <= on_port.chroma_blue;
            req_luma_second <= on_port.luma_second;
            req_chroma_red  <= on_port.chroma_red;
            req_frame_end   <= on_port.frame_end;
            idle_cycles     <= on_port.gap;
            start           <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: every rsp_valid cycle is one response, checked against the
   // oldest expectation.
   // ------------------------------------------------------------------
   task automatic check_field(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
      if (got !== want) begin
         $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rgb_pair_type want;
      if (!reset && rsp_valid) begin
         if (rgb_expected.size() == 0) begin
            $display("%0t unexpected response: red_first %0d, frame_end_out %0b",
                     $time, rsp_red_first, rsp_frame_end_out);
            mismatch_count++;
         end else begin
            want = rgb_expected.pop_front();
            check_field("red_first",     want.first.red,     rsp_red_first);
            check_field("green_first",   want.first.green,   rsp_green_first);
            check_field("blue_first",    want.first.blue,    rsp_blue_first);
            check_field("red_second",    want.second.red,    rsp_red_second);
            check_field("green_second",  want.second.green,  rsp_green_second);
            check_field("blue_second",   want.second.blue,   rsp_blue_second);
            check_field("frame_end_out", PIX_W'(want.frame_end), PIX_W'(rsp_frame_end_out));
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int unsigned gap;
      reset = 1'b1;

      // Directed: rails, neutral gray, each channel clamping low and high,
      // the two lumas far apart, frame_end both ways. Back to back at first.
      add_request(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 0, 0);
      add_request(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 0, 0);
      add_request(8'h00, 8'h80, 8'h00, 8'h80, 1'b0, 0, 0);  // black, no chroma
      add_request(8'hFF, 8'h80, 8'hFF, 8'h80, 1'b0, 0, 0);  // white, no chroma
      add_request(8'h80, 8'h80, 8'h80, 8'h80, 1'b1, 1, 0);
      add_request(8'h00, 8'h80, 8'hFF, 8'h80, 1'b0, 0, 0);  // first dark, second bright
      add_request(8'hFF, 8'h80, 8'h00, 8'h80, 1'b0, 2, 0);
      add_request(8'h00, 8'h80, 8'h10, 8'h00, 1'b0, 0, 0);  // red below zero
      add_request(8'hFF, 8'h80, 8'hF0, 8'hFF, 1'b0, 0, 0);  // red above 255
      add_request(8'h00, 8'hFF, 8'h08, 8'hFF, 1'b0, 3, 0);  // green below zero
      add_request(8'hFF, 8'h00, 8'hF8, 8'h00, 1'b1, 0, 0);  // green above 255
      add_request(8'h00, 8'h00, 8'h20, 8'h80, 1'b0, 5, 0);  // blue below zero
      add_request(8'hFF, 8'hFF, 8'hE0, 8'h80, 1'b0, 0, 0);  // blue above 255
      add_request(8'h7F, 8'h7F, 8'h81, 8'h81, 1'b0, 4, 0);  // just off neutral
      add_request(8'h55, 8'hAA, 8'hAA, 8'h55, 1'b1, 0, 0);  // alternating bits
      add_request(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0, 0, 0);
      add_request(8'hFE, 8'h01, 8'h01, 8'hFE, 1'b0, 0, 1);  // after a full drain

      // Random: blocks alternate between back-to-back bursts and random gaps.
      // Two requests wait for the pipe to drain first.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         gap = ((n / BURST_LEN) % 2 == 0) ? 0 : $urandom_range(0, MAX_GAP);
         add_request(pick_luma(), pick_chroma(), pick_luma(), pick_chroma(),
                     ($urandom_range(0, 7) == 0), gap,
                     (n == RANDOM_REQUESTS / 2) || (n == RANDOM_REQUESTS - 3));
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // all requests taken, then all responses in, then a quiet tail
      while (pending_requests.size() != 0 || start) @(posedge clock);
      while (rgb_expected.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #(RUN_LIMIT);
      $display("Mismatches found");
      $finish;
   end

endmodule

@@ filelist.f @@
src/yuyv_pkg.sv
src/yuyv_mult.sv
src/yuyv_sum_clamp.sv
src/yuyv_scale.sv
src/yuyv_to_rgb_converter.sv
src/yuyv_checker.sv
test/testbench.sv
